[sv/rgb_color_key_centroid_core_macros.svh]
// Assertion macros shared by the color key centroid modules.
`ifndef RGB_COLOR_KEY_CENTROID_CORE_MACROS_SVH
`define RGB_COLOR_KEY_CENTROID_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CKC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ckc: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define CKC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ckc: next-cycle check failed");

`endif

[sv/ckc_pkg.sv]
// Types and constants of the color key centroid block.
package ckc_pkg;

    localparam int COLOR_W   = 8;
    localparam int COORD_W   = 11;
    localparam int QUO_W     = 11;
    localparam int SQ_W      = 2 * COLOR_W;
    localparam int DIST_W    = SQ_W + 2;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_BLUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_GREEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_RED   = 2'd3;

    localparam logic [COLOR_W-1:0] RST_THRESHOLD = 8'd20;
    localparam logic [COLOR_W-1:0] RST_REF_BLUE  = 8'd51;
    localparam logic [COLOR_W-1:0] RST_REF_GREEN = 8'd42;
    localparam logic [COLOR_W-1:0] RST_REF_RED   = 8'd91;

    typedef struct packed {
        logic [COLOR_W-1:0] pix_blue;
        logic [COLOR_W-1:0] pix_green;
        logic [COLOR_W-1:0] pix_red;
        logic [COORD_W-1:0] col_pos;
        logic [COORD_W-1:0] row_pos;
        logic               frame_last;
    } pix_t;

    typedef struct packed {
        logic               mask_on;
        logic               frame_done;
        logic               center_valid;
        logic [COORD_W-1:0] center_col;
        logic [COORD_W-1:0] center_row;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_KEY,
        ST_DIV,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic key_en;
        logic div_step;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic pix_valid;
        logic last;
        logic out_free;
    } sts_t;

endpackage

[sv/ckc_if.sv]
// Pixel and result stream interfaces with valid/ready handshake.
interface ckc_pix_if;
    logic          valid;
    logic          ready;
    ckc_pkg::pix_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ckc_res_if;
    logic          valid;
    logic          ready;
    ckc_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/ckc_datapath.sv]
// Datapath: config registers, color distance, accumulators, divider, output register.
`include "rgb_color_key_centroid_core_macros.svh"

module ckc_datapath #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ckc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  ckc_pkg::cmd_t                       cmd,
    output ckc_pkg::sts_t                       sts,
    ckc_pix_if.sink                             pix,
    ckc_res_if.source                           res
);

    localparam int CAP   = MAX_COLS * MAX_ROWS;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int SUM_W = CNT_W + ckc_pkg::COORD_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);

    // configuration
    logic [ckc_pkg::COLOR_W-1:0] thr_reg;
    logic [ckc_pkg::COLOR_W-1:0] ref_b_reg;
    logic [ckc_pkg::COLOR_W-1:0] ref_g_reg;
    logic [ckc_pkg::COLOR_W-1:0] ref_r_reg;

    // captured pixel
    logic [ckc_pkg::COLOR_W-1:0] diff_b_reg;
    logic [ckc_pkg::COLOR_W-1:0] diff_g_reg;
    logic [ckc_pkg::COLOR_W-1:0] diff_r_reg;
    logic [ckc_pkg::COORD_W-1:0] col_reg;
    logic [ckc_pkg::COORD_W-1:0] row_reg;
    logic                        last_reg;

    // squares
    logic [ckc_pkg::SQ_W-1:0]    sq_b_reg;
    logic [ckc_pkg::SQ_W-1:0]    sq_g_reg;
    logic [ckc_pkg::SQ_W-1:0]    sq_r_reg;
    logic [ckc_pkg::SQ_W-1:0]    thr_sq_reg;

    // accumulators
    logic [SUM_W-1:0]            sum_col_reg;
    logic [SUM_W-1:0]            sum_row_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [SUM_W-1:0]            sum_col_acc;
    logic [SUM_W-1:0]            sum_row_acc;
    logic [CNT_W-1:0]            cnt_acc;
    logic [SUM_W-1:0]            sum_col_next;
    logic [SUM_W-1:0]            sum_row_next;
    logic [CNT_W-1:0]            cnt_next;

    // divider
    logic [SUM_W-1:0]            rem_col_reg;
    logic [SUM_W-1:0]            rem_row_reg;
    logic [SUM_W-1:0]            dsh_reg;
    logic [ckc_pkg::QUO_W-1:0]   q_col_reg;
    logic [ckc_pkg::QUO_W-1:0]   q_row_reg;
    logic                        center_ok_reg;
    logic                        mask_reg;

    logic [ckc_pkg::DIST_W-1:0]  dist_sq;
    logic                        keyed;
    logic                        acc_en;
    logic                        col_ge;
    logic                        row_ge;

    logic                        res_valid_reg;
    logic                        res_valid_next;
    ckc_pkg::res_t               res_data_reg;
    ckc_pkg::res_t               res_load;
    logic                        out_free;
    logic                        pix_acc;

    function automatic logic [ckc_pkg::COLOR_W-1:0] abs_diff(
        input logic [ckc_pkg::COLOR_W-1:0] a,
        input logic [ckc_pkg::COLOR_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign pix_acc  = pix.valid && cmd.in_ready;
    assign out_free = !res_valid_reg || res.ready;

    assign pix.ready     = cmd.in_ready;
    assign sts.pix_valid = pix.valid;
    assign sts.last      = last_reg;
    assign sts.out_free  = out_free;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= ckc_pkg::RST_THRESHOLD;
            ref_b_reg <= ckc_pkg::RST_REF_BLUE;
            ref_g_reg <= ckc_pkg::RST_REF_GREEN;
            ref_r_reg <= ckc_pkg::RST_REF_RED;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ckc_pkg::CFG_THRESHOLD: thr_reg   <= cfg_data;
                ckc_pkg::CFG_REF_BLUE:  ref_b_reg <= cfg_data;
                ckc_pkg::CFG_REF_GREEN: ref_g_reg <= cfg_data;
                ckc_pkg::CFG_REF_RED:   ref_r_reg <= cfg_data;
                default:                thr_reg   <= thr_reg;
            endcase
        end
    end

    // capture beat and per-channel differences
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            diff_b_reg <= abs_diff(pix.data.pix_blue,  ref_b_reg);
            diff_g_reg <= abs_diff(pix.data.pix_green, ref_g_reg);
            diff_r_reg <= abs_diff(pix.data.pix_red,   ref_r_reg);
            col_reg    <= pix.data.col_pos;
            row_reg    <= pix.data.row_pos;
            last_reg   <= pix.data.frame_last;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_b_reg   <= diff_b_reg * diff_b_reg;
        sq_g_reg   <= diff_g_reg * diff_g_reg;
        sq_r_reg   <= diff_r_reg * diff_r_reg;
        thr_sq_reg <= thr_reg * thr_reg;
    end

    assign dist_sq = ckc_pkg::DIST_W'(sq_b_reg) + ckc_pkg::DIST_W'(sq_g_reg)
                   + ckc_pkg::DIST_W'(sq_r_reg);
    assign keyed   = dist_sq < ckc_pkg::DIST_W'(thr_sq_reg);
    assign acc_en  = keyed && (cnt_reg < CAP_C);

    always_comb
    begin
        sum_col_acc = sum_col_reg;
        sum_row_acc = sum_row_reg;
        cnt_acc     = cnt_reg;
        if (acc_en)
        begin
            sum_col_acc = sum_col_reg + SUM_W'(col_reg);
            sum_row_acc = sum_row_reg + SUM_W'(row_reg);
            cnt_acc     = cnt_reg + CNT_W'(1);
        end
        sum_col_next = sum_col_reg;
        sum_row_next = sum_row_reg;
        cnt_next     = cnt_reg;
        if (cmd.key_en)
        begin
            if (last_reg)
            begin
                sum_col_next = '0;
                sum_row_next = '0;
                cnt_next     = '0;
            end
            else
            begin
                sum_col_next = sum_col_acc;
                sum_row_next = sum_row_acc;
                cnt_next     = cnt_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_col_reg <= '0;
            sum_row_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            sum_col_reg <= sum_col_next;
            sum_row_reg <= sum_row_next;
            cnt_reg     <= cnt_next;
        end
    end

    // restoring division, one quotient bit per step, MSB first
    assign col_ge = rem_col_reg >= dsh_reg;
    assign row_ge = rem_row_reg >= dsh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.key_en)
        begin
            mask_reg      <= keyed;
            rem_col_reg   <= sum_col_acc;
            rem_row_reg   <= sum_row_acc;
            dsh_reg       <= SUM_W'({cnt_acc, (ckc_pkg::QUO_W - 1)'(0)});
            center_ok_reg <= cnt_acc != '0;
        end
        else if (cmd.div_step)
        begin
            if (col_ge)
            begin
                rem_col_reg <= rem_col_reg - dsh_reg;
            end
            if (row_ge)
            begin
                rem_row_reg <= rem_row_reg - dsh_reg;
            end
            q_col_reg <= {q_col_reg[ckc_pkg::QUO_W-2:0], col_ge};
            q_row_reg <= {q_row_reg[ckc_pkg::QUO_W-2:0], row_ge};
            dsh_reg   <= dsh_reg >> 1;
        end
    end

    // result beat: straight from the key stage, or from held state
    always_comb
    begin
        res_load = '0;
        if (cmd.key_en)
        begin
            res_load.mask_on = keyed;
        end
        else
        begin
            res_load.mask_on      = mask_reg;
            res_load.frame_done   = last_reg;
            res_load.center_valid = last_reg && center_ok_reg;
            if (last_reg && center_ok_reg)
            begin
                res_load.center_col = q_col_reg;
                res_load.center_row = q_row_reg;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.push)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            res_data_reg <= res_load;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    `CKC_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, cnt_reg <= CAP_C)
    `CKC_ASSERT_NXT(a_frame_clear, clk, rst_n, cmd.key_en && last_reg, cnt_reg == '0 && sum_col_reg == '0 && sum_row_reg == '0)
    `CKC_ASSERT_IMP(a_no_overrun, clk, rst_n, cmd.push, out_free)

endmodule

[sv/ckc_ctrl.sv]
// Controller: sequences capture, squaring, keying, division and result load.
`include "rgb_color_key_centroid_core_macros.svh"

module ckc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  ckc_pkg::sts_t sts,
    output ckc_pkg::cmd_t cmd
);

    ckc_pkg::state_t                  state_reg;
    ckc_pkg::state_t                  state_next;
    logic [ckc_pkg::DIV_CNT_W-1:0]    div_cnt_reg;
    logic [ckc_pkg::DIV_CNT_W-1:0]    div_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ckc_pkg::ST_IDLE:
            begin
                if (sts.pix_valid)
                begin
                    state_next = ckc_pkg::ST_SQUARE;
                end
            end
            ckc_pkg::ST_SQUARE:
            begin
                state_next = ckc_pkg::ST_KEY;
            end
            ckc_pkg::ST_KEY:
            begin
                if (sts.last)
                begin
                    state_next   = ckc_pkg::ST_DIV;
                    div_cnt_next = '0;
                end
                else if (sts.out_free)
                begin
                    state_next = ckc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = ckc_pkg::ST_PUSH;
                end
            end
            ckc_pkg::ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == ckc_pkg::DIV_LAST)
                begin
                    state_next = ckc_pkg::ST_PUSH;
                end
            end
            ckc_pkg::ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = ckc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ckc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ckc_pkg::ST_IDLE:   cmd.in_ready = 1'b1;
            ckc_pkg::ST_SQUARE: cmd = '0;
            ckc_pkg::ST_KEY:
            begin
                cmd.key_en = 1'b1;
                cmd.push   = !sts.last && sts.out_free;
            end
            ckc_pkg::ST_DIV:    cmd.div_step = 1'b1;
            ckc_pkg::ST_PUSH:   cmd.push = sts.out_free;
            default:            cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ckc_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    `CKC_ASSERT_NXT(a_accept_to_square, clk, rst_n, cmd.in_ready && sts.pix_valid, state_reg == ckc_pkg::ST_SQUARE)
    `CKC_ASSERT_IMP(a_div_count_range, clk, rst_n, state_reg == ckc_pkg::ST_DIV, div_cnt_reg <= ckc_pkg::DIV_LAST)
    `CKC_ASSERT_IMP(a_push_when_free, clk, rst_n, cmd.push, sts.out_free)

endmodule

[sv/rgb_color_key_centroid_core.sv]
// Top level of the color key centroid block: controller plus datapath.
// Each pixel is captured, its squares registered, then it is keyed; a plain pixel's
//   result is loaded in the key state, or in a push state that waits for a free
//   output. A frame's last pixel first runs the restoring centroid divider, one
//   quotient bit per cycle; no new pixel is taken until the result is loaded.
// Reset: rst_n is asynchronous, active low; registers return to their reset values.
module rgb_color_key_centroid_core #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0] cfg_data,
    ckc_pix_if.sink                        pix,
    ckc_res_if.source                      res
);

    ckc_pkg::cmd_t cmd;
    ckc_pkg::sts_t sts;

    ckc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ckc_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .pix       (pix),
        .res       (res)
    );

endmodule
